### rtl/core/ttyld_pkg.sv
// shared types and constants of the terminal line discipline buffer
package ttyld_pkg;

    localparam int DEF_BUFFER_DEPTH = 256;
    localparam int MAX_READ         = 32;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_C     = 8'h43;

    localparam logic       RST_CANON     = 1'b1;
    localparam logic       RST_ECHO      = 1'b1;
    localparam logic       RST_NONBLOCK  = 1'b0;
    localparam logic [7:0] RST_ERASE     = 8'd127;
    localparam logic [7:0] RST_MIN_CHARS = 8'd1;
    localparam logic       RST_SIGNALS   = 1'b1;

    typedef enum logic [1:0] {
        OP_RECV  = 2'd0,
        OP_READ  = 2'd1,
        OP_INTR  = 2'd2,
        OP_FLUSH = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_ECHO = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_END  = 2'd2,
        KIND_INTR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        RD_OK      = 2'd0,
        RD_WBLOCK  = 2'd1,
        RD_NO_LINE = 2'd2
    } t_rd_status;

    typedef enum logic [2:0] {
        CFG_CANON     = 3'd0,
        CFG_ECHO      = 3'd1,
        CFG_NONBLOCK  = 3'd2,
        CFG_ERASE     = 3'd3,
        CFG_MIN_CHARS = 3'd4,
        CFG_SIGNALS   = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PLAN_NONE  = 3'd0,
        PLAN_ECHO  = 3'd1,
        PLAN_END   = 3'd2,
        PLAN_SCAN  = 3'd3,
        PLAN_FETCH = 3'd4
    } t_plan;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_code;
        logic [5:0] read_len;
    } t_req;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [1:0] status;
        logic [5:0] byte_count;
        logic       last;
    } t_res;

    typedef struct packed {
        logic accept;
        logic emit_echo;
        logic addr_scan;
        logic scan_next;
        logic set_noline;
        logic emit_byte;
        logic emit_end;
    } t_dp_cmd;

    typedef struct packed {
        t_plan plan;
        logic  seq_last;
        logic  scan_done;
        logic  scan_nl;
        logic  fetch_more;
        logic  byte_stop;
    } t_dp_stat;

endpackage

### rtl/core/ttyld_ram.sv
// generic single-port-write, single-port-read ram with registered read
module ttyld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/ttyld_ctrl.sv
// controller state machine sequencing requests, reads and echo output
module ttyld_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ttyld_pkg::t_dp_stat i_stat,
    output ttyld_pkg::t_dp_cmd  o_cmd,
    output logic                o_busy
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ECHO  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_FETCH = 7'b0010000,
        S_BYTE  = 7'b0100000,
        S_END   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_stat.plan)
                        ttyld_pkg::PLAN_ECHO:  n_state = S_ECHO;
                        ttyld_pkg::PLAN_END:   n_state = S_END;
                        ttyld_pkg::PLAN_SCAN:  n_state = S_SCAN;
                        ttyld_pkg::PLAN_FETCH: n_state = S_FETCH;
                        default:               n_state = S_IDLE;
                    endcase
                end
            end
            S_ECHO: begin
                o_cmd.emit_echo = 1'b1;
                if (i_stat.seq_last) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.addr_scan = 1'b1;
                if (i_stat.scan_done) begin
                    o_cmd.set_noline = 1'b1;
                    n_state          = S_END;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.scan_nl) begin
                    n_state = S_FETCH;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_FETCH: begin
                n_state = i_stat.fetch_more ? S_BYTE : S_END;
            end
            S_BYTE: begin
                o_cmd.emit_byte = 1'b1;
                n_state         = i_stat.byte_stop ? S_END : S_FETCH;
            end
            S_END: begin
                o_cmd.emit_end = 1'b1;
                n_state        = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### rtl/core/ttyld_dp.sv
// datapath: ring indices, configuration, line editing and result register
module ttyld_dp #(
    parameter int BUFFER_DEPTH = ttyld_pkg::DEF_BUFFER_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ttyld_pkg::t_req                 i_req,
    input  logic                            i_cfg_we,
    input  logic [2:0]                      i_cfg_index,
    input  logic [7:0]                      i_cfg_wdata,
    input  ttyld_pkg::t_dp_cmd              i_cmd,
    output ttyld_pkg::t_dp_stat             o_stat,
    output logic                            o_ram_we,
    output logic [$clog2(BUFFER_DEPTH)-1:0] o_ram_waddr,
    output logic [7:0]                      o_ram_wdata,
    output logic [$clog2(BUFFER_DEPTH)-1:0] o_ram_raddr,
    input  logic [7:0]                      i_ram_rdata,
    output logic                            o_res_valid,
    output ttyld_pkg::t_res                 o_res
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_DEPTH - 1);

    typedef enum logic [1:0] {
        SEQ_CHAR  = 2'd0,
        SEQ_ERASE = 2'd1,
        SEQ_INTR  = 2'd2
    } t_seq;

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + AW'(1);
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
        return (i == '0) ? LAST_IDX : i - AW'(1);
    endfunction

    // configuration
    logic       r_canon, r_echo, r_nonblock, r_sig;
    logic [7:0] r_erase, r_min;

    // ring control
    logic [AW-1:0] r_wr, r_rd, r_lb, r_scan;
    logic [AW-1:0] n_wr, n_rd, n_lb, n_scan;

    // read and echo progress
    logic [5:0] r_len, r_got, n_len, n_got;
    logic [1:0] r_status, n_status;
    t_seq       r_seq_type, n_seq_type;
    logic [1:0] r_seq_idx, n_seq_idx;
    logic [7:0] r_seq_char, n_seq_char;

    logic            r_out_valid, n_out_valid;
    ttyld_pkg::t_res r_out, n_out;

    // decode of the offered request
    logic [7:0]       d_char;
    logic             d_erase;
    logic [AW-1:0]    d_wr_next;
    ttyld_pkg::t_plan d_plan;
    logic [5:0]       d_len;
    logic [7:0]       need;
    logic [5:0]       got_inc;
    logic [7:0]       echo_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canon     <= ttyld_pkg::RST_CANON;
            r_echo      <= ttyld_pkg::RST_ECHO;
            r_nonblock  <= ttyld_pkg::RST_NONBLOCK;
            r_erase     <= ttyld_pkg::RST_ERASE;
            r_min       <= ttyld_pkg::RST_MIN_CHARS;
            r_sig       <= ttyld_pkg::RST_SIGNALS;
            r_wr        <= '0;
            r_rd        <= '0;
            r_lb        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (ttyld_pkg::t_cfg_idx'(i_cfg_index))
                    ttyld_pkg::CFG_CANON:     r_canon    <= i_cfg_wdata[0];
                    ttyld_pkg::CFG_ECHO:      r_echo     <= i_cfg_wdata[0];
                    ttyld_pkg::CFG_NONBLOCK:  r_nonblock <= i_cfg_wdata[0];
                    ttyld_pkg::CFG_ERASE:     r_erase    <= i_cfg_wdata;
                    ttyld_pkg::CFG_MIN_CHARS: r_min      <= i_cfg_wdata;
                    ttyld_pkg::CFG_SIGNALS:   r_sig      <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            r_wr        <= n_wr;
            r_rd        <= n_rd;
            r_lb        <= n_lb;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_len      <= n_len;
        r_got      <= n_got;
        r_status   <= n_status;
        r_seq_type <= n_seq_type;
        r_seq_idx  <= n_seq_idx;
        r_seq_char <= n_seq_char;
        r_out      <= n_out;
    end

    // request decode, independent of the handshake
    always_comb begin
        d_char    = (r_canon && i_req.char_code == ttyld_pkg::CH_CR) ? ttyld_pkg::CH_LF
                                                                     : i_req.char_code;
        d_erase   = r_canon && (d_char == ttyld_pkg::CH_BS || d_char == r_erase);
        d_wr_next = idx_inc(r_wr);
        d_len     = (i_req.read_len > 6'(ttyld_pkg::MAX_READ)) ? 6'(ttyld_pkg::MAX_READ)
                                                               : i_req.read_len;
        d_plan    = ttyld_pkg::PLAN_NONE;
        unique case (ttyld_pkg::t_opcode'(i_req.opcode))
            ttyld_pkg::OP_RECV: begin
                if (d_erase) begin
                    if (r_wr != r_lb && r_echo) d_plan = ttyld_pkg::PLAN_ECHO;
                end else if (d_wr_next != r_rd && r_echo) begin
                    d_plan = ttyld_pkg::PLAN_ECHO;
                end
            end
            ttyld_pkg::OP_READ: begin
                if (r_nonblock && r_wr == r_rd) begin
                    d_plan = ttyld_pkg::PLAN_END;
                end else if (r_canon) begin
                    d_plan = ttyld_pkg::PLAN_SCAN;
                end else begin
                    d_plan = ttyld_pkg::PLAN_FETCH;
                end
            end
            ttyld_pkg::OP_INTR: begin
                if (r_sig) d_plan = ttyld_pkg::PLAN_ECHO;
            end
            ttyld_pkg::OP_FLUSH: d_plan = ttyld_pkg::PLAN_NONE;
            default:             d_plan = ttyld_pkg::PLAN_NONE;
        endcase
    end

    always_comb begin
        need    = (r_min == 8'd0) ? 8'd1 : r_min;
        got_inc = r_got + 6'd1;

        unique case (r_seq_type)
            SEQ_CHAR:  echo_byte = r_seq_char;
            SEQ_ERASE: echo_byte = (r_seq_idx == 2'd1) ? ttyld_pkg::CH_SP : ttyld_pkg::CH_BS;
            SEQ_INTR: begin
                unique case (r_seq_idx)
                    2'd1:    echo_byte = ttyld_pkg::CH_CARET;
                    2'd2:    echo_byte = ttyld_pkg::CH_C;
                    2'd3:    echo_byte = ttyld_pkg::CH_LF;
                    default: echo_byte = 8'd0;
                endcase
            end
            default:   echo_byte = 8'd0;
        endcase

        o_stat.plan = d_plan;
        unique case (r_seq_type)
            SEQ_ERASE: o_stat.seq_last = (r_seq_idx == 2'd2);
            SEQ_INTR:  o_stat.seq_last = r_echo ? (r_seq_idx == 2'd3) : (r_seq_idx == 2'd0);
            default:   o_stat.seq_last = 1'b1;
        endcase
        o_stat.scan_done  = (r_scan == r_wr);
        o_stat.scan_nl    = (i_ram_rdata == ttyld_pkg::CH_LF);
        o_stat.fetch_more = (r_got < r_len) && (r_rd != r_wr);
        o_stat.byte_stop  = r_canon ? (i_ram_rdata == ttyld_pkg::CH_LF)
                                    : ({2'b00, got_inc} >= need);
    end

    always_comb begin
        n_wr        = r_wr;
        n_rd        = r_rd;
        n_lb        = r_lb;
        n_scan      = r_scan;
        n_len       = r_len;
        n_got       = r_got;
        n_status    = r_status;
        n_seq_type  = r_seq_type;
        n_seq_idx   = r_seq_idx;
        n_seq_char  = r_seq_char;
        n_out_valid = 1'b0;
        n_out       = '0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_wr;
        o_ram_wdata = d_char;
        o_ram_raddr = i_cmd.addr_scan ? r_scan : r_rd;

        if (i_cmd.accept) begin
            n_seq_idx  = 2'd0;
            n_seq_char = d_char;
            unique case (ttyld_pkg::t_opcode'(i_req.opcode))
                ttyld_pkg::OP_RECV: begin
                    if (d_erase) begin
                        n_seq_type = SEQ_ERASE;
                        // never erase back past the start of the line
                        if (r_wr != r_lb) n_wr = idx_dec(r_wr);
                    end else begin
                        n_seq_type = SEQ_CHAR;
                        if (d_wr_next != r_rd) begin
                            o_ram_we = 1'b1;
                            n_wr     = d_wr_next;
                            if (r_canon && d_char == ttyld_pkg::CH_LF) n_lb = d_wr_next;
                        end
                    end
                end
                ttyld_pkg::OP_READ: begin
                    n_len    = d_len;
                    n_got    = 6'd0;
                    n_scan   = r_rd;
                    n_status = (r_nonblock && r_wr == r_rd) ? ttyld_pkg::RD_WBLOCK
                                                             : ttyld_pkg::RD_OK;
                end
                ttyld_pkg::OP_INTR: begin
                    n_seq_type = SEQ_INTR;
                    if (r_sig) n_wr = r_lb;
                end
                ttyld_pkg::OP_FLUSH: begin
                    n_rd = r_wr;
                    n_lb = r_wr;
                end
                default: ;
            endcase
        end

        if (i_cmd.scan_next)  n_scan   = idx_inc(r_scan);
        if (i_cmd.set_noline) n_status = ttyld_pkg::RD_NO_LINE;

        if (i_cmd.emit_echo) begin
            n_seq_idx       = r_seq_idx + 2'd1;
            n_out_valid     = 1'b1;
            n_out.kind      = (r_seq_type == SEQ_INTR && r_seq_idx == 2'd0) ?
                              ttyld_pkg::KIND_INTR : ttyld_pkg::KIND_ECHO;
            n_out.data_byte = echo_byte;
            n_out.last      = o_stat.seq_last;
        end

        if (i_cmd.emit_byte) begin
            n_rd            = idx_inc(r_rd);
            n_got           = got_inc;
            n_out_valid     = 1'b1;
            n_out.kind      = ttyld_pkg::KIND_BYTE;
            n_out.data_byte = i_ram_rdata;
        end

        if (i_cmd.emit_end) begin
            n_out_valid      = 1'b1;
            n_out.kind       = ttyld_pkg::KIND_END;
            n_out.status     = r_status;
            n_out.byte_count = r_got;
            n_out.last       = 1'b1;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

### rtl/core/tty_line_discipline_buffer.sv
// top level of the terminal input ring buffer with canonical line editing
//
// A request is taken when i_start is high and o_busy is low; each result shows on
// o_res for one cycle with o_res_valid high and cannot be held off, so the receiver
// must take it then. Results leave through an output register, in the cycle after the
// controller makes them. With echo on, a received character that is stored gives one
// echo result and an erase that removes a character echoes backspace, space and
// backspace. With signals enabled an interrupt key gives an interrupt result, then
// ^, C and newline echoes when echo is on; a flush gives no result. A read gives each
// stored byte as a result, then an end result once it stops on a newline, the raw
// minimum, the length or an empty ring; in canonical mode it first examines bytes
// while looking for the newline. A read that finds no complete line, and a would_block
// read, give only the end result. The ring is one memory with a registered read
// port, walked one entry at a time; its contents need no initialisation after reset.
module tty_line_discipline_buffer #(
    parameter int BUFFER_DEPTH = ttyld_pkg::DEF_BUFFER_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  ttyld_pkg::t_req i_req,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_index,
    input  logic [7:0]      i_cfg_wdata,
    output logic            o_res_valid,
    output ttyld_pkg::t_res o_res
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    ttyld_pkg::t_dp_cmd  cmd;
    ttyld_pkg::t_dp_stat stat;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    ttyld_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    ttyld_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    ttyld_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule
